// ----- sv/msp_frame_parser_defines.svh -----
// Assertion macros for the MSP frame parser.
// Used by msp_frame_parser.sv; needs clk and arst_n in the including scope.
`ifndef MSP_FRAME_PARSER_DEFINES_SVH
`define MSP_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define MSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSP_ASSERT(lbl, prop, msg)
`define MSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/msp_pkg.sv -----
// Shared types, codes and helper functions for the MSP frame parser.
// No dependencies; used by msp_parse_core and msp_frame_parser.
package msp_pkg;

	localparam int FRAME_BYTES_DEF = 256;

	// command codes
	localparam logic [1:0] CMD_DATA     = 2'd0;
	localparam logic [1:0] CMD_CLI_ON   = 2'd1;
	localparam logic [1:0] CMD_CLI_OFF  = 2'd2;
	localparam logic [1:0] CMD_CONSUMED = 2'd3;

	// parser states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_START    = 4'd1;
	localparam logic [3:0] ST_M        = 4'd2;
	localparam logic [3:0] ST_X        = 4'd3;
	localparam logic [3:0] ST_HDR_V1   = 4'd4;
	localparam logic [3:0] ST_PAY_V1   = 4'd5;
	localparam logic [3:0] ST_CK_V1    = 4'd6;
	localparam logic [3:0] ST_HDR_TUN  = 4'd7;
	localparam logic [3:0] ST_PAY_TUN  = 4'd8;
	localparam logic [3:0] ST_CK_TUN   = 4'd9;
	localparam logic [3:0] ST_HDR_NAT  = 4'd10;
	localparam logic [3:0] ST_PAY_NAT  = 4'd11;
	localparam logic [3:0] ST_CK_NAT   = 4'd12;
	localparam logic [3:0] ST_MSP_DONE = 4'd13;
	localparam logic [3:0] ST_CLI_LINE = 4'd14;
	localparam logic [3:0] ST_CLI_DONE = 4'd15;

	// frame kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_V1   = 3'd1;
	localparam logic [2:0] KIND_TUN  = 3'd2;
	localparam logic [2:0] KIND_NAT  = 3'd3;
	localparam logic [2:0] KIND_CLI  = 3'd4;

	// protocol characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [7:0] CRC_POLY        = 8'hD5;
	localparam logic [7:0] TUNNEL_CMD      = 8'hFF;
	localparam logic [7:0] TUNNEL_MIN_SIZE = 8'd6;
	localparam logic [15:0] TUN_SIZE_LO_AT = 16'd6;
	localparam logic [15:0] NAT_SIZE_LO_AT = 16'd4;
	localparam int          BOOT_LEN       = 9;

	typedef struct packed {
		logic [3:0]  state;
		logic [15:0] field_offset;
		logic [7:0]  xor_check;
		logic [7:0]  crc_check;
		logic [15:0] payload_size;
		logic [7:0]  size_low_byte;
		logic [2:0]  kind;
		logic        boot_match;  // CLI line so far matches the reboot banner
	} msp_state_t;

	typedef struct packed {
		logic       frame_valid;
		logic       cli_mode;
		logic [2:0] frame_kind;
		logic [8:0] frame_length;
		logic       byte_stored;
		logic [7:0] store_index;
		logic [7:0] store_byte;
	} msp_result_t;

	// CRC-8 DVB-S2 update for one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	// "Rebooting"
	function automatic logic [7:0] boot_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h52;
			4'd1: c = 8'h65;
			4'd2: c = 8'h62;
			4'd3: c = 8'h6F;
			4'd4: c = 8'h6F;
			4'd5: c = 8'h74;
			4'd6: c = 8'h69;
			4'd7: c = 8'h6E;
			4'd8: c = 8'h67;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/msp_parse_core.sv -----
// Next-state and result logic of the MSP frame parser for one item.
// Purely combinational; uses msp_pkg types, codes and functions.
module msp_parse_core #(
	parameter int FRAME_BYTES = msp_pkg::FRAME_BYTES_DEF
) (
	input  msp_pkg::msp_state_t           cur,
	input  logic [$clog2(FRAME_BYTES)-1:0] cur_cnt,
	input  logic [1:0]                    cmd,
	input  logic [7:0]                    data_byte,
	output msp_pkg::msp_state_t           nxt,
	output logic [$clog2(FRAME_BYTES)-1:0] nxt_cnt,
	output msp_pkg::msp_result_t          res
);
	localparam int CW   = $clog2(FRAME_BYTES);
	localparam int SUMW = ((CW > 16) ? CW : 16) + 2;

	always_comb begin
		logic [CW-1:0]   cnt;
		logic [SUMW-1:0] cnt_after;  // count after this byte is stored
		logic [SUMW-1:0] size_base;  // count after this byte, plus one
		logic [15:0]     fo_n;
		logic [15:0]     psize;
		logic [15:0]     lo_at;
		logic            put;
		logic            tun;
		logic            in_cli;
		logic            boot_n;
		logic            done;

		nxt       = cur;
		cnt       = cur_cnt;
		cnt_after = '0;
		size_base = '0;
		put       = 1'b0;
		fo_n      = cur.field_offset + 16'd1;
		psize     = {data_byte, cur.size_low_byte};
		tun       = 1'b0;
		lo_at     = msp_pkg::NAT_SIZE_LO_AT;
		boot_n    = 1'b0;
		in_cli    = (cur.state == msp_pkg::ST_CLI_LINE) || (cur.state == msp_pkg::ST_CLI_DONE);

		case (cmd)
			msp_pkg::CMD_DATA: begin
				// buffer nearly full: restart as from idle
				if (SUMW'(cur_cnt) + SUMW'(1) >= SUMW'(FRAME_BYTES)) begin
					cnt       = '0;
					nxt.state = msp_pkg::ST_IDLE;
				end
				cnt_after = SUMW'(cnt) + SUMW'(1);
				size_base = SUMW'(cnt) + SUMW'(2);
				case (nxt.state)
					msp_pkg::ST_START: begin
						if (data_byte == msp_pkg::CH_M || data_byte == msp_pkg::CH_X) begin
							nxt.state = (data_byte == msp_pkg::CH_M) ? msp_pkg::ST_M
								: msp_pkg::ST_X;
							put              = 1'b1;
							nxt.field_offset = '0;
						end else begin
							nxt.state = msp_pkg::ST_IDLE;
						end
					end
					msp_pkg::ST_M, msp_pkg::ST_X: begin
						if (data_byte == msp_pkg::CH_LT || data_byte == msp_pkg::CH_GT) begin
							put              = 1'b1;
							nxt.field_offset = '0;
							nxt.crc_check    = '0;
							if (nxt.state == msp_pkg::ST_M) begin
								nxt.state     = msp_pkg::ST_HDR_V1;
								nxt.xor_check = '0;
								nxt.kind      = msp_pkg::KIND_V1;
							end else begin
								nxt.state = msp_pkg::ST_HDR_NAT;
								nxt.kind  = msp_pkg::KIND_NAT;
							end
						end else begin
							nxt.state = msp_pkg::ST_IDLE;
						end
					end
					msp_pkg::ST_HDR_V1: begin
						put              = 1'b1;
						nxt.xor_check    = cur.xor_check ^ data_byte;
						nxt.field_offset = fo_n;
						if (fo_n == 16'd1) begin
							nxt.size_low_byte = data_byte;
						end else if (fo_n == 16'd2) begin
							if (SUMW'(cur.size_low_byte) + size_base > SUMW'(FRAME_BYTES)) begin
								nxt.state = msp_pkg::ST_IDLE;
							end else if (data_byte == msp_pkg::TUNNEL_CMD) begin
								if (cur.size_low_byte >= msp_pkg::TUNNEL_MIN_SIZE) begin
									nxt.state = msp_pkg::ST_HDR_TUN;
									nxt.kind  = msp_pkg::KIND_TUN;
								end else begin
									nxt.state = msp_pkg::ST_IDLE;
								end
							end else begin
								nxt.payload_size = {8'd0, cur.size_low_byte};
								nxt.field_offset = '0;
								nxt.state = (cur.size_low_byte != 8'd0) ? msp_pkg::ST_PAY_V1
									: msp_pkg::ST_CK_V1;
							end
						end
					end
					msp_pkg::ST_PAY_V1: begin
						put              = 1'b1;
						nxt.field_offset = fo_n;
						nxt.xor_check    = cur.xor_check ^ data_byte;
						if (fo_n == cur.payload_size)
							nxt.state = msp_pkg::ST_CK_V1;
					end
					msp_pkg::ST_CK_V1: begin
						put       = 1'b1;
						nxt.state = (cur.xor_check == data_byte) ? msp_pkg::ST_MSP_DONE
							: msp_pkg::ST_IDLE;
					end
					msp_pkg::ST_HDR_TUN, msp_pkg::ST_HDR_NAT: begin
						tun              = (nxt.state == msp_pkg::ST_HDR_TUN);
						lo_at            = tun ? msp_pkg::TUN_SIZE_LO_AT : msp_pkg::NAT_SIZE_LO_AT;
						put              = 1'b1;
						nxt.field_offset = fo_n;
						if (tun)
							nxt.xor_check = cur.xor_check ^ data_byte;
						nxt.crc_check = msp_pkg::crc8_step(cur.crc_check, data_byte);
						if (fo_n == lo_at) begin
							nxt.size_low_byte = data_byte;
						end else if (fo_n == lo_at + 16'd1) begin
							nxt.payload_size = psize;
							if (SUMW'(psize) + size_base + SUMW'(tun) > SUMW'(FRAME_BYTES)) begin
								nxt.state = msp_pkg::ST_IDLE;
							end else begin
								nxt.field_offset = '0;
								if (tun)
									nxt.state = (psize != 16'd0) ? msp_pkg::ST_PAY_TUN
										: msp_pkg::ST_CK_TUN;
								else
									nxt.state = (psize != 16'd0) ? msp_pkg::ST_PAY_NAT
										: msp_pkg::ST_CK_NAT;
							end
						end
					end
					msp_pkg::ST_PAY_TUN, msp_pkg::ST_PAY_NAT: begin
						tun              = (nxt.state == msp_pkg::ST_PAY_TUN);
						put              = 1'b1;
						nxt.field_offset = fo_n;
						if (tun)
							nxt.xor_check = cur.xor_check ^ data_byte;
						nxt.crc_check = msp_pkg::crc8_step(cur.crc_check, data_byte);
						if (fo_n == cur.payload_size)
							nxt.state = tun ? msp_pkg::ST_CK_TUN : msp_pkg::ST_CK_NAT;
					end
					msp_pkg::ST_CK_TUN: begin
						put           = 1'b1;
						nxt.xor_check = cur.xor_check ^ data_byte;
						nxt.state     = (cur.crc_check == data_byte) ? msp_pkg::ST_CK_V1
							: msp_pkg::ST_IDLE;
					end
					msp_pkg::ST_CK_NAT: begin
						put       = 1'b1;
						nxt.state = (cur.crc_check == data_byte) ? msp_pkg::ST_MSP_DONE
							: msp_pkg::ST_IDLE;
					end
					msp_pkg::ST_CLI_LINE: begin
						put = 1'b1;
						// banner match tracked per position over the first bytes of the line
						if (SUMW'(cnt) < SUMW'(msp_pkg::BOOT_LEN)) begin
							boot_n = ((cnt == '0) || cur.boot_match)
								&& (data_byte == msp_pkg::boot_char(cnt[3:0]));
							nxt.boot_match = boot_n;
						end
						if (data_byte == msp_pkg::CH_NL) begin
							nxt.state = msp_pkg::ST_CLI_DONE;
							nxt.kind  = msp_pkg::KIND_CLI;
						end else if (cnt_after == SUMW'(msp_pkg::BOOT_LEN) && boot_n) begin
							nxt.state = msp_pkg::ST_MSP_DONE;
							nxt.kind  = msp_pkg::KIND_CLI;
						end
					end
					default: begin
						// idle and both done states: a new frame starts here
						cnt = '0;
						put = 1'b1;
						if (data_byte == msp_pkg::CH_DOLLAR) begin
							nxt.state = msp_pkg::ST_START;
						end else if (data_byte == msp_pkg::CH_HASH) begin
							nxt.state = msp_pkg::ST_CLI_DONE;
							nxt.kind  = msp_pkg::KIND_CLI;
						end else begin
							nxt.state = msp_pkg::ST_IDLE;
						end
					end
				endcase
			end
			msp_pkg::CMD_CLI_ON: begin
				if (!in_cli) begin
					cnt       = '0;
					nxt.state = msp_pkg::ST_CLI_LINE;
				end
			end
			msp_pkg::CMD_CLI_OFF: begin
				nxt.state = msp_pkg::ST_IDLE;
			end
			default: begin
				if (cur.state == msp_pkg::ST_CLI_DONE) begin
					cnt       = '0;
					nxt.state = msp_pkg::ST_CLI_LINE;
				end else if (cur.state != msp_pkg::ST_CLI_LINE) begin
					nxt.state = msp_pkg::ST_IDLE;
				end
			end
		endcase

		nxt_cnt = cnt + CW'(put);
		done    = (nxt.state == msp_pkg::ST_MSP_DONE) || (nxt.state == msp_pkg::ST_CLI_DONE);

		res.frame_valid  = done;
		res.cli_mode     = (nxt.state == msp_pkg::ST_CLI_LINE)
			|| (nxt.state == msp_pkg::ST_CLI_DONE);
		res.frame_kind   = done ? nxt.kind : msp_pkg::KIND_NONE;
		res.frame_length = 9'(nxt_cnt);
		res.byte_stored  = put;
		res.store_index  = put ? 8'(cnt) : 8'd0;
		res.store_byte   = put ? data_byte : 8'd0;
	end

endmodule

// ----- sv/msp_frame_parser.sv -----
// Top level of the MSP frame parser: parser state, result register and skid stage.
// Depends on msp_pkg, msp_parse_core and msp_frame_parser_defines.svh.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall | cmd, data_byte
//  out     | source    | out_valid/out_stall | frame_valid, cli_mode, frame_kind,
//          |           |                     | frame_length, byte_stored, store_index,
//          |           |                     | store_byte
//
// One item per cycle while in_stall is low; the whole parse step is combinational, from the
// state registers into the result register, or into the skid entry while the output stalls.
// A two-entry output buffer (result register plus skid) keeps in_stall registered:
// in_stall rises only while the skid entry is occupied.
// arst_n clears the parser state and both output valid flags.
`include "msp_frame_parser_defines.svh"

module msp_frame_parser #(
	parameter int FRAME_BYTES = msp_pkg::FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_valid,
	output logic       cli_mode,
	output logic [2:0] frame_kind,
	output logic [8:0] frame_length,
	output logic       byte_stored,
	output logic [7:0] store_index,
	output logic [7:0] store_byte
);
	localparam int CW = $clog2(FRAME_BYTES);

	msp_pkg::msp_state_t  st_q;
	msp_pkg::msp_state_t  st_nxt;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_nxt;
	msp_pkg::msp_result_t res_nxt;
	msp_pkg::msp_result_t out_q;
	msp_pkg::msp_result_t skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic                 accept;
	logic                 out_free;

	msp_parse_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.cur      (st_q),
		.cur_cnt  (cnt_q),
		.cmd      (cmd),
		.data_byte(data_byte),
		.nxt      (st_nxt),
		.nxt_cnt  (cnt_nxt),
		.res      (res_nxt)
	);

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			st_q  <= st_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res_nxt;
		end else if (accept) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_valid  = out_q.frame_valid;
	assign cli_mode     = out_q.cli_mode;
	assign frame_kind   = out_q.frame_kind;
	assign frame_length = out_q.frame_length;
	assign byte_stored  = out_q.byte_stored;
	assign store_index  = out_q.store_index;
	assign store_byte   = out_q.store_byte;

	`MSP_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with empty output register")
	`MSP_ASSERT(a_done_has_kind, (out_valid_q && out_q.frame_valid) |-> (out_q.frame_kind != msp_pkg::KIND_NONE), "held frame reported without a kind")
	`MSP_ASSERT(a_tunnel_kind, (st_q.state == msp_pkg::ST_HDR_TUN || st_q.state == msp_pkg::ST_PAY_TUN || st_q.state == msp_pkg::ST_CK_TUN) |-> (st_q.kind == msp_pkg::KIND_TUN), "tunnel state without tunnel kind")
	`MSP_ASSERT(a_no_store_on_cmd, (accept && cmd != msp_pkg::CMD_DATA) |-> !res_nxt.byte_stored, "control command stored a byte")

endmodule

// ----- tb/msp_frame_parser_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for msp_frame_parser: MSP v1/v2/tunnel frames, CLI lines, control cmds.
// Depends on msp_pkg (codes, result struct) and the msp_frame_parser RTL; predicts every item.
module msp_frame_parser_test;
	import msp_pkg::*;

	localparam int BUF_BYTES = FRAME_BYTES_DEF;
	localparam logic [8*BOOT_LEN-1:0] BOOT_BANNER = "Rebooting";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = CMD_DATA;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       frame_valid;
	logic       cli_mode;
	logic [2:0] frame_kind;
	logic [8:0] frame_length;
	logic       byte_stored;
	logic [7:0] store_index;
	logic [7:0] store_byte;

	msp_frame_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_valid  (frame_valid),
		.cli_mode     (cli_mode),
		.frame_kind   (frame_kind),
		.frame_length (frame_length),
		.byte_stored  (byte_stored),
		.store_index  (store_index),
		.store_byte   (store_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser shadow state
	logic [3:0]  m_state = ST_IDLE;
	int          m_fill = 0;
	logic [15:0] m_offs = '0;
	logic [15:0] m_size = '0;
	logic [7:0]  m_xor = '0;
	logic [7:0]  m_crc = '0;
	logic [7:0]  m_lo = '0;
	logic [2:0]  m_kind = KIND_NONE;
	logic [7:0]  m_buf [BUF_BYTES];
	msp_result_t m_res;

	msp_result_t status_q [$];
	int          mismatches = 0;
	int          items_sent = 0;
	bit          gap_on = 1'b0;
	bit          stall_on = 1'b0;

	function automatic logic [7:0] dvb_crc(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
		return r;
	endfunction

	function automatic bit in_cli_state();
		return m_state == ST_CLI_LINE || m_state == ST_CLI_DONE;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		m_buf[m_fill] = b;
		m_res.byte_stored = 1'b1;
		m_res.store_index = 8'(m_fill);
		m_res.store_byte = b;
		m_fill++;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		bit tun;
		int lo_at;
		bit banner;
		if (m_fill + 1 >= BUF_BYTES) begin
			m_fill = 0;
			m_state = ST_IDLE;
		end
		case (m_state)
			ST_START: begin
				if (b == CH_M || b == CH_X) begin
					m_state = (b == CH_M) ? ST_M : ST_X;
					put_byte(b);
					m_offs = '0;
				end else begin
					m_state = ST_IDLE;
				end
			end
			ST_M, ST_X: begin
				if (b == CH_LT || b == CH_GT) begin
					put_byte(b);
					m_offs = '0;
					m_crc = '0;
					if (m_state == ST_M) begin
						m_state = ST_HDR_V1;
						m_xor = '0;
						m_kind = KIND_V1;
					end else begin
						m_state = ST_HDR_NAT;
						m_kind = KIND_NAT;
					end
				end else begin
					m_state = ST_IDLE;
				end
			end
			ST_HDR_V1: begin
				m_xor ^= b;
				put_byte(b);
				m_offs = m_offs + 16'd1;
				if (m_offs == 16'd1) begin
					m_lo = b;
				end else if (m_offs == 16'd2) begin
					if (int'(m_lo) + m_fill + 1 > BUF_BYTES) begin
						m_state = ST_IDLE;
					end else if (b == TUNNEL_CMD) begin
						if (m_lo >= TUNNEL_MIN_SIZE) begin
							m_state = ST_HDR_TUN;
							m_kind = KIND_TUN;
						end else begin
							m_state = ST_IDLE;
						end
					end else begin
						m_size = {8'h00, m_lo};
						m_offs = '0;
						m_state = (m_size != '0) ? ST_PAY_V1 : ST_CK_V1;
					end
				end
			end
			ST_PAY_V1: begin
				put_byte(b);
				m_offs = m_offs + 16'd1;
				m_xor ^= b;
				if (m_offs == m_size) m_state = ST_CK_V1;
			end
			ST_CK_V1: begin
				put_byte(b);
				m_state = (m_xor == b) ? ST_MSP_DONE : ST_IDLE;
			end
			ST_HDR_TUN, ST_HDR_NAT: begin
				tun = (m_state == ST_HDR_TUN);
				// tunnel offset keeps counting from the two outer v1 header bytes
				lo_at = tun ? int'(TUN_SIZE_LO_AT) : int'(NAT_SIZE_LO_AT);
				put_byte(b);
				m_offs = m_offs + 16'd1;
				if (tun) m_xor ^= b;
				m_crc = dvb_crc(m_crc, b);
				if (int'(m_offs) == lo_at) begin
					m_lo = b;
				end else if (int'(m_offs) == lo_at + 1) begin
					m_size = {b, m_lo};
					if (int'(m_size) + m_fill + (tun ? 2 : 1) > BUF_BYTES) begin
						m_state = ST_IDLE;
					end else begin
						m_offs = '0;
						if (tun) m_state = (m_size != '0) ? ST_PAY_TUN : ST_CK_TUN;
						else m_state = (m_size != '0) ? ST_PAY_NAT : ST_CK_NAT;
					end
				end
			end
			ST_PAY_TUN, ST_PAY_NAT: begin
				put_byte(b);
				m_offs = m_offs + 16'd1;
				if (m_state == ST_PAY_TUN) m_xor ^= b;
				m_crc = dvb_crc(m_crc, b);
				if (m_offs == m_size) m_state = (m_state == ST_PAY_TUN) ? ST_CK_TUN : ST_CK_NAT;
			end
			ST_CK_TUN: begin
				put_byte(b);
				m_xor ^= b;
				m_state = (m_crc == b) ? ST_CK_V1 : ST_IDLE;
			end
			ST_CK_NAT: begin
				put_byte(b);
				m_state = (m_crc == b) ? ST_MSP_DONE : ST_IDLE;
			end
			ST_CLI_LINE: begin
				put_byte(b);
				if (b == CH_NL) begin
					m_state = ST_CLI_DONE;
					m_kind = KIND_CLI;
				end else if (m_fill == BOOT_LEN) begin
					banner = 1'b1;
					for (int i = 0; i < BOOT_LEN; i++)
						if (m_buf[i] != BOOT_BANNER[8*(BOOT_LEN-1-i) +: 8]) banner = 1'b0;
					if (banner) begin
						m_state = ST_MSP_DONE;
						m_kind = KIND_CLI;
					end
				end
			end
			default: begin
				// idle and both done states: a byte starts over
				m_fill = 0;
				if (b == CH_DOLLAR) begin
					m_state = ST_START;
				end else if (b == CH_HASH) begin
					m_state = ST_CLI_DONE;
					m_kind = KIND_CLI;
				end else begin
					m_state = ST_IDLE;
				end
				put_byte(b);
			end
		endcase
	endfunction

	function automatic msp_result_t advance_parser(input logic [1:0] c, input logic [7:0] b);
		bit held;
		m_res = '0;
		case (c)
			CMD_DATA: parse_byte(b);
			CMD_CLI_ON: begin
				if (!in_cli_state()) begin
					m_fill = 0;
					m_state = ST_CLI_LINE;
				end
			end
			CMD_CLI_OFF: m_state = ST_IDLE;
			CMD_CONSUMED: begin
				if (m_state == ST_CLI_DONE) begin
					m_fill = 0;
					m_state = ST_CLI_LINE;
				end else if (m_state != ST_CLI_LINE) begin
					m_state = ST_IDLE;
				end
			end
		endcase
		held = (m_state == ST_MSP_DONE || m_state == ST_CLI_DONE);
		m_res.frame_valid = held;
		m_res.cli_mode = in_cli_state();
		m_res.frame_kind = held ? m_kind : KIND_NONE;
		m_res.frame_length = 9'(m_fill);
		return m_res;
	endfunction

	task automatic send_item(input logic [1:0] c, input logic [7:0] b);
		if (gap_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		status_q.push_back(advance_parser(c, b));
		items_sent++;
	endtask

	task automatic compare_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (got !== want) begin
			if (mismatches < 40)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		msp_result_t got;
		msp_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			got = {frame_valid, cli_mode, frame_kind, frame_length, byte_stored, store_index,
				store_byte};
			if (status_q.size() == 0) begin
				if (mismatches < 40)
					$display("%0t: unexpected result, expected none actual %p", $time, got);
				mismatches++;
			end else begin
				want = status_q.pop_front();
				compare_field("frame_valid", want.frame_valid, got.frame_valid);
				compare_field("cli_mode", want.cli_mode, got.cli_mode);
				compare_field("frame_kind", want.frame_kind, got.frame_kind);
				compare_field("frame_length", want.frame_length, got.frame_length);
				compare_field("byte_stored", want.byte_stored, got.byte_stored);
				compare_field("store_index", want.store_index, got.store_index);
				compare_field("store_byte", want.store_byte, got.store_byte);
			end
		end
	end

	// receiver backpressure in bursts
	always begin
		@(posedge clk);
		if (stall_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom);
		return (b == CH_NL) ? 8'h20 : b;
	endfunction

	// one MSP frame of the given kind, sometimes damaged or cut short
	task automatic send_msp_frame(input logic [2:0] fkind);
		logic [7:0]  q [$];
		logic [7:0]  hdr [5];
		logic [7:0]  dir, x, c, pb, v1len;
		logic [15:0] len, mcmd;
		int          n_pay, pos;
		dir = $urandom_range(0, 1) ? CH_LT : CH_GT;
		mcmd = 16'($urandom);
		len = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(100, 250)) :
			16'($urandom_range(0, 12));
		if (fkind != KIND_V1 && $urandom_range(0, 19) == 0) len[15:8] = 8'($urandom);
		n_pay = (len > 16'd250) ? 8 : int'(len);
		q = {CH_DOLLAR, (fkind == KIND_NAT) ? CH_X : CH_M, dir};
		if (fkind == KIND_V1) begin
			q.push_back(len[7:0]);
			q.push_back(mcmd[7:0]);
			x = len[7:0] ^ mcmd[7:0];
			repeat (int'(len[7:0])) begin
				pb = 8'($urandom);
				q.push_back(pb);
				x ^= pb;
			end
			q.push_back(x);
		end else begin
			hdr = '{8'($urandom), mcmd[7:0], mcmd[15:8], len[7:0], len[15:8]};
			x = '0;
			c = '0;
			if (fkind == KIND_TUN) begin
				// outer size is normally the v2 frame, now and then a small value, mostly too short to tunnel
				v1len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 7)) :
					len[7:0] + 8'd6;
				q.push_back(v1len);
				q.push_back(TUNNEL_CMD);
				x = v1len ^ TUNNEL_CMD;
			end
			foreach (hdr[i]) begin
				q.push_back(hdr[i]);
				c = dvb_crc(c, hdr[i]);
				x ^= hdr[i];
			end
			repeat (n_pay) begin
				pb = 8'($urandom);
				q.push_back(pb);
				c = dvb_crc(c, pb);
				x ^= pb;
			end
			q.push_back(c);
			x ^= c;
			if (fkind == KIND_TUN) q.push_back(x);
		end
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, q.size() - 1);
			if ($urandom_range(0, 1)) q[pos] ^= 8'($urandom_range(1, 255));
			else while (q.size() > pos + 1) void'(q.pop_back());
		end
		foreach (q[i]) send_item(CMD_DATA, q[i]);
		if ($urandom_range(0, 1)) send_item(CMD_CONSUMED, 8'($urandom));
	endtask

	task automatic send_cli_session();
		send_item(CMD_CLI_ON, 8'($urandom));
		repeat ($urandom_range(1, 3)) begin
			repeat ($urandom_range(0, 12)) send_item(CMD_DATA, text_byte());
			if ($urandom_range(0, 3) != 0) send_item(CMD_DATA, CH_NL);
			send_item(($urandom_range(0, 4) == 0) ? CMD_CLI_ON : CMD_CONSUMED, 8'($urandom));
		end
		if ($urandom_range(0, 1)) send_item(CMD_CLI_OFF, 8'($urandom));
	endtask

	task automatic send_boot_line();
		logic [7:0] b;
		int         bad;
		bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, BOOT_LEN - 1) : BOOT_LEN;
		send_item(CMD_CLI_ON, 8'($urandom));
		for (int i = 0; i < BOOT_LEN; i++) begin
			b = BOOT_BANNER[8*(BOOT_LEN-1-i) +: 8];
			if (i == bad) b ^= 8'($urandom_range(1, 255));
			send_item(CMD_DATA, b);
		end
		repeat ($urandom_range(0, 3)) send_item(CMD_DATA, text_byte());
		if ($urandom_range(0, 1)) send_item(CMD_CONSUMED, 8'($urandom));
	endtask

	task automatic test_v1_frame();
		send_item(CMD_DATA, CH_DOLLAR);
		send_item(CMD_DATA, CH_M);
		send_item(CMD_DATA, CH_GT);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_CONSUMED, 8'h00);
	endtask

	task automatic test_native_frame();
		logic [7:0] hdr [5];
		logic [7:0] c;
		hdr = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
		c = '0;
		send_item(CMD_DATA, CH_DOLLAR);
		send_item(CMD_DATA, CH_X);
		send_item(CMD_DATA, CH_LT);
		foreach (hdr[i]) begin
			send_item(CMD_DATA, hdr[i]);
			c = dvb_crc(c, hdr[i]);
		end
		send_item(CMD_DATA, c);
		// next start byte drops the held frame
		send_item(CMD_DATA, CH_DOLLAR);
	endtask

	task automatic test_cli_mode();
		send_item(CMD_CLI_ON, 8'h00);
		send_item(CMD_CLI_ON, 8'hFF);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, CH_NL);
		send_item(CMD_CONSUMED, 8'h00);
		send_item(CMD_CLI_OFF, 8'h00);
		send_item(CMD_DATA, CH_HASH);
		send_item(CMD_CONSUMED, 8'hFF);
	endtask

	task automatic test_random_traffic(input int count, input bit with_idling);
		int target;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			if (with_idling && $urandom_range(0, 9) == 0) begin
				gap_on = $urandom_range(0, 1);
				stall_on = $urandom_range(0, 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				send_msp_frame(KIND_V1);
			end else if (pick < 37) begin
				send_msp_frame(KIND_TUN);
			end else if (pick < 55) begin
				send_msp_frame(KIND_NAT);
			end else if (pick < 68) begin
				send_cli_session();
			end else if (pick < 74) begin
				send_boot_line();
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
			end else if (pick < 99) begin
				send_item(CMD_DATA, CH_HASH);
				repeat ($urandom_range(0, 2)) send_item(CMD_CONSUMED, 8'($urandom));
				repeat ($urandom_range(0, 4)) send_item(CMD_DATA, text_byte());
			end else begin
				// line that overruns the buffer
				send_item(CMD_CLI_ON, 8'($urandom));
				repeat (258) send_item(CMD_DATA, text_byte());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		gap_on = 1'b1;
		stall_on = 1'b1;
		test_v1_frame();
		test_native_frame();
		test_cli_mode();
		test_random_traffic(1600, 1'b1);
		gap_on = 1'b0;
		stall_on = 1'b0;
		test_random_traffic(300, 1'b0);
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/msp_pkg.sv
sv/msp_parse_core.sv
sv/msp_frame_parser.sv
tb/msp_frame_parser_test.sv
